// ----- design/sorted_table_binary_search_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Shared property forms for the checker of the search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("search block property violated");

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("search block property violated");

`endif

// ----- design/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: package
// Transaction types, request codes and fixed widths shared by the design.
// ----------------------------------------------------------------------------
package stbs_pkg;

   // Fixed field widths.
   localparam int IDX_W   = 10;
   localparam int CNT_W   = 11;
   localparam int VAL_W   = 32;
   // Search bounds run from minus one up to the entry count; differences
   // reach one more than the largest count, so one extra bit is kept.
   localparam int BOUND_W = 13;

   localparam logic signed [BOUND_W-1:0] BOUND_MINUS_ONE = -13'sd1;
   localparam logic signed [BOUND_W-1:0] BOUND_ZERO      = 13'sd0;
   localparam logic signed [BOUND_W-1:0] BOUND_ONE       = 13'sd1;

   // Request codes.
   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_EXACT  = 2'd1;
   localparam logic [1:0] REQ_LOWER  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Input transaction.
   typedef struct packed {
      logic [1:0]              req_type;
      logic [IDX_W-1:0]        entry_index;
      logic signed [VAL_W-1:0] entry_value;
      logic signed [VAL_W-1:0] search_key;
   } req_item_type;

   // Result transaction.
   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] position;
   } rsp_item_type;

endpackage

// ----- design/stbs_table_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stbs_table_ram
   import stbs_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic signed [VAL_W-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic signed [VAL_W-1:0] rd_data
);

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search
// Stores a table of signed 32-bit entries and runs exact and lower-bound
// binary searches over its first entry_count entries.
// ----------------------------------------------------------------------------
// A write transaction stores one entry and gives no result; busy stays low.
// A search holds busy high while it probes and shows its result on rsp_item
// with rsp_valid for one cycle right after the last probe. One probe is
// made each cycle through the single read port of the table memory: the
// registered read data is compared and the next midpoint is addressed in the
// same cycle. A lower-bound search over n entries makes about log2(n+1)
// probes (at most 11 for 1024 entries); an exact search makes at most
// floor(log2(n)) + 1 and stops early on a hit. An empty table gives its
// result in the cycle after start. A new transaction may start in the
// cycle its predecessor's result is shown; the receiver cannot stall, so a
// result must be taken when rsp_valid is high. The table has no reset and
// only written entries may be searched.
module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          n_ff, n_in, n_cur;
   logic                      exact_ff, exact_in;
   logic signed [VAL_W-1:0]   key_ff, key_in;
   logic signed [BOUND_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [BOUND_W-1:0] lo0, hi0, mid0, lo_nx, hi_nx, mid_nx;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_item_ff, rsp_item_in;

   logic                      accept, is_search, hit, cont;
   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic signed [VAL_W-1:0]   rd_data;

   // Entry count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // Count saturated to the table depth.
   assign n_cur = (32'(count_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_ff;

   assign busy      = (state_ff == ST_PROBE);
   assign accept    = start && !busy;
   assign is_search = (req_item.req_type == REQ_EXACT) || (req_item.req_type == REQ_LOWER);

   // Initial bounds of a new search.
   always_comb begin
      if (req_item.req_type == REQ_EXACT) begin
         lo0 = BOUND_ZERO;
         hi0 = $signed({{(BOUND_W-CNT_W){1'b0}}, n_cur}) + BOUND_MINUS_ONE;
      end else begin
         lo0 = BOUND_MINUS_ONE;
         hi0 = $signed({{(BOUND_W-CNT_W){1'b0}}, n_cur});
      end
      mid0 = lo0 + ((hi0 - lo0) >>> 1);
   end

   // One probe step on the entry read at the current midpoint.
   always_comb begin
      hit   = 1'b0;
      lo_nx = lo_ff;
      hi_nx = hi_ff;
      if (exact_ff) begin
         hit = (rd_data == key_ff);
         if (key_ff < rd_data) begin
            hi_nx = mid_ff + BOUND_MINUS_ONE;
         end else begin
            lo_nx = mid_ff + BOUND_ONE;
         end
         cont = !hit && (hi_nx >= lo_nx);
      end else begin
         if (!(rd_data < key_ff)) begin
            hi_nx = mid_ff;
         end else begin
            lo_nx = mid_ff;
         end
         cont = ((hi_nx - lo_nx) > BOUND_ONE);
      end
      mid_nx = lo_nx + ((hi_nx - lo_nx) >>> 1);
   end

   // Sequencer, memory addressing and result formation.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      exact_in     = exact_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = AW'($unsigned(mid0));
      wr_addr      = AW'(req_item.entry_index);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.req_type == REQ_WRITE)) begin
               wr_en = (32'(req_item.entry_index) < TABLE_DEPTH);
            end
            if (accept && is_search) begin
               n_in     = n_cur;
               exact_in = (req_item.req_type == REQ_EXACT);
               key_in   = req_item.search_key;
               lo_in    = lo0;
               hi_in    = hi0;
               mid_in   = mid0;
               if (n_cur == '0) begin
                  // Empty table: both searches report not found at zero.
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '0;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            lo_in   = lo_nx;
            hi_in   = hi_nx;
            mid_in  = mid_nx;
            rd_addr = AW'($unsigned(mid_nx));
            if (cont) begin
               rd_en = 1'b1;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (exact_ff) begin
                  rsp_item_in.found    = hit;
                  rsp_item_in.position = hit ? CNT_W'($unsigned(mid_ff)) : '0;
               end else begin
                  rsp_item_in.found    = (hi_nx < $signed({{(BOUND_W-CNT_W){1'b0}}, n_ff}));
                  rsp_item_in.position = CNT_W'($unsigned(hi_nx));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search and result payload registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      exact_ff    <= exact_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Table memory.
   stbs_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- design/stbs_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: port checker
// Watches the ports of the search block for ordering errors over time.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_assert.svh"

module stbs_checker
   import stbs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid
);

   logic acc_search, acc_other;

   assign acc_search = start && !busy &&
                       ((req_item.req_type == REQ_EXACT) || (req_item.req_type == REQ_LOWER));
   assign acc_other  = start && !busy &&
                       ((req_item.req_type == REQ_WRITE) || (req_item.req_type == REQ_UNUSED));

   // A result ends its search, so the block is free while it is shown.
   `STBS_ASSERT_NOW(a_rsp_not_busy, clock, reset, rsp_valid, !busy)

   // A result only follows a search in progress or one just started.
   `STBS_ASSERT_NOW(a_rsp_has_cause, clock, reset, rsp_valid, $past(busy) || $past(start))

   // A write or unused transaction neither blocks nor answers.
   `STBS_ASSERT_NEXT(a_other_silent, clock, reset, acc_other, !busy && !rsp_valid)

   // A started search either probes or answers at once.
   `STBS_ASSERT_NEXT(a_search_moves, clock, reset, acc_search, busy || rsp_valid)

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
